// ===== design/rpn_pkg.sv =====
// ---------------------------------------------------------------------------
// rpn_pkg
// Shared constants, codes and handshake structs of the RPN stack calculator.
// ---------------------------------------------------------------------------
package rpn_pkg;

    // default sizes
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_VALUE_BITS  = 32;

    // fixed-point format and port widths
    localparam int FRAC_BITS = 16;
    localparam int IO_BITS   = 32;
    localparam int CMD_W     = 3;
    localparam int DEPTH_W   = 5;
    localparam int ST_W      = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_SHORT = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
    localparam logic [ST_W-1:0] ST_DIVZ  = 3'd3;
    localparam logic [ST_W-1:0] ST_OVF   = 3'd4;

    // operation of the shared arithmetic unit
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    // request to the arithmetic unit
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } rpn_alu_req_t;

    // response from the arithmetic unit
    typedef struct packed {
        logic            done;
        logic [ST_W-1:0] status;
    } rpn_alu_rsp_t;

endpackage

// ===== design/rpn_alu.sv =====
// ---------------------------------------------------------------------------
// rpn_alu
// Iterative signed fixed-point unit around one shared adder: add and
// subtract in one step, shift-add multiply one bit a step, restoring
// divide one quotient bit a step, then saturation and sign fix-up.
// ---------------------------------------------------------------------------
module rpn_alu #(
    parameter int VALUE_BITS = rpn_pkg::DEF_VALUE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rpn_pkg::rpn_alu_req_t  req,
    input  logic [VALUE_BITS-1:0]  left_op,
    input  logic [VALUE_BITS-1:0]  right_op,
    output rpn_pkg::rpn_alu_rsp_t  rsp,
    output logic [VALUE_BITS-1:0]  result
);
    import rpn_pkg::*;

    localparam int W    = VALUE_BITS;
    localparam int QW   = VALUE_BITS + FRAC_BITS;
    localparam int CNTW = $clog2(QW);
    localparam logic [W-1:0] SIGN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXP_W = ~SIGN_W;

    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_FIX
    } state_t;

    state_t            state_reg;
    alu_op_t           op_reg;
    logic              ls_reg;
    logic              rs_reg;
    logic              lzero_reg;
    logic [W-1:0]      mr_reg;
    logic [W-1:0]      acc_reg;
    logic [W-1:0]      lo_reg;
    logic [QW-1:0]     quo_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [W-1:0]      res_reg;
    logic [ST_W-1:0]   status_reg;
    logic              done_reg;

    logic [W-1:0]      mag_l;
    logic [W-1:0]      mag_r;
    logic [W-1:0]      rem_sh;
    logic [W:0]        add_a;
    logic [W:0]        add_b;
    logic              add_cin;
    logic [W:0]        add_sum;
    logic              div_ge;

    logic [2*W-1:0]    prod_shift;
    logic [W-1:0]      mag_low;
    logic              upper_nz;
    logic              neg;
    logic [W-1:0]      limit;
    logic [W-1:0]      low_neg;
    logic              ovf;
    logic [W-1:0]      fix_res;
    logic [ST_W-1:0]   fix_status;

    // operand magnitudes; the most negative word maps to 2^(W-1)
    assign mag_l = left_op[W-1]  ? (W'(0) - left_op)  : left_op;
    assign mag_r = right_op[W-1] ? (W'(0) - right_op) : right_op;

    // shared adder with operand selection
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        rem_sh  = {acc_reg[W-2:0], quo_reg[QW-1]};
        unique case (op_reg)
            ALU_ADD: begin
                add_a = {acc_reg[W-1], acc_reg};
                add_b = {mr_reg[W-1], mr_reg};
            end
            ALU_SUB: begin
                add_a   = {acc_reg[W-1], acc_reg};
                add_b   = ~{mr_reg[W-1], mr_reg};
                add_cin = 1'b1;
            end
            ALU_MUL: begin
                add_a = {1'b0, acc_reg};
                add_b = lo_reg[0] ? {1'b0, mr_reg} : '0;
            end
            ALU_DIV: begin
                add_a   = {1'b0, rem_sh};
                add_b   = ~{1'b0, mr_reg};
                add_cin = 1'b1;
            end
        endcase
        add_sum = add_a + add_b + {{W{1'b0}}, add_cin};
    end

    // trial subtract succeeds when no borrow out
    assign div_ge = ~add_sum[W];

    // saturation and sign fix-up
    always_comb begin
        prod_shift = {acc_reg, lo_reg} >> FRAC_BITS;
        neg        = ls_reg ^ rs_reg;
        limit      = neg ? SIGN_W : MAXP_W;
        if (op_reg == ALU_MUL) begin
            mag_low  = prod_shift[W-1:0];
            upper_nz = |prod_shift[2*W-1:W];
        end else begin
            mag_low  = quo_reg[W-1:0];
            upper_nz = |quo_reg[QW-1:W];
        end
        low_neg    = W'(0) - mag_low;
        ovf        = 1'b0;
        fix_res    = lo_reg;
        fix_status = ST_OK;
        unique case (op_reg)
            ALU_ADD: begin
                ovf     = (ls_reg == rs_reg) && (lo_reg[W-1] != ls_reg);
                fix_res = ovf ? (ls_reg ? SIGN_W : MAXP_W) : lo_reg;
            end
            ALU_SUB: begin
                ovf     = (ls_reg != rs_reg) && (lo_reg[W-1] != ls_reg);
                fix_res = ovf ? (ls_reg ? SIGN_W : MAXP_W) : lo_reg;
            end
            ALU_MUL, ALU_DIV: begin
                ovf     = upper_nz || (mag_low > limit);
                fix_res = ovf ? limit : (neg ? low_neg : mag_low);
            end
        endcase
        fix_status = ovf ? ST_OVF : ST_OK;
        // divide by zero overrides the iteration result
        if (op_reg == ALU_DIV && mr_reg == '0) begin
            fix_status = ST_DIVZ;
            fix_res    = lzero_reg ? '0 : (ls_reg ? SIGN_W : MAXP_W);
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            op_reg    <= ALU_ADD;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        op_reg    <= req.op;
                        ls_reg    <= left_op[W-1];
                        rs_reg    <= right_op[W-1];
                        lzero_reg <= (left_op == '0);
                        unique case (req.op)
                            ALU_ADD, ALU_SUB: begin
                                acc_reg <= left_op;
                                mr_reg  <= right_op;
                                cnt_reg <= '0;
                            end
                            ALU_MUL: begin
                                acc_reg <= '0;
                                lo_reg  <= mag_l;
                                mr_reg  <= mag_r;
                                cnt_reg <= CNTW'(W - 1);
                            end
                            ALU_DIV: begin
                                acc_reg <= '0;
                                quo_reg <= {mag_l, {FRAC_BITS{1'b0}}};
                                mr_reg  <= mag_r;
                                cnt_reg <= CNTW'(QW - 1);
                            end
                        endcase
                        state_reg <= A_RUN;
                    end
                end
                A_RUN: begin
                    unique case (op_reg)
                        ALU_ADD, ALU_SUB: begin
                            lo_reg <= add_sum[W-1:0];
                        end
                        ALU_MUL: begin
                            acc_reg <= add_sum[W:1];
                            lo_reg  <= {add_sum[0], lo_reg[W-1:1]};
                        end
                        ALU_DIV: begin
                            acc_reg <= div_ge ? add_sum[W-1:0] : rem_sh;
                            quo_reg <= {quo_reg[QW-2:0], div_ge};
                        end
                    endcase
                    if (cnt_reg == '0) begin
                        state_reg <= A_FIX;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                A_FIX: begin
                    res_reg    <= fix_res;
                    status_reg <= fix_status;
                    done_reg   <= 1'b1;
                    state_reg  <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.status = status_reg;
    assign result     = res_reg;

endmodule

// ===== design/rpn_stack_calculator_unit.sv =====
// ---------------------------------------------------------------------------
// rpn_stack_calculator_unit
// Reverse Polish calculator on a bounded stack of signed Q16.16 words.
// ---------------------------------------------------------------------------
// One command beat at a time: a push, a short-stack operator, a full-stack
// push or an unknown command goes from accept straight to the finish state;
// add, subtract, multiply and divide pass through the start and execute
// states and wait there for the arithmetic unit, whose shared adder handles
// one product or quotient bit per cycle. The stack lives in a memory with
// one write and one registered read port plus a top-of-stack register; the
// result beat waits in an output register while the block is idle and ready
// for the next command.
// ---------------------------------------------------------------------------
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_BITS  = rpn_pkg::DEF_VALUE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rpn_pkg::CMD_W-1:0]          s_command,
    input  logic signed [rpn_pkg::IO_BITS-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [rpn_pkg::IO_BITS-1:0] m_top_value,
    output logic [rpn_pkg::DEPTH_W-1:0]        m_stack_depth,
    output logic [rpn_pkg::ST_W-1:0]           m_status
);
    import rpn_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_EXEC,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [VALUE_BITS-1:0]   top_reg, top_next;
    logic [ST_W-1:0]         status_reg, status_next;
    alu_op_t                 op_reg, op_next;
    logic                    m_valid_reg, m_valid_next;
    logic [IO_BITS-1:0]      m_top_reg, m_top_next;
    logic [DEPTH_W-1:0]      m_depth_reg, m_depth_next;
    logic [ST_W-1:0]         m_status_reg, m_status_next;

    logic [VALUE_BITS-1:0]   mem [STACK_DEPTH];
    logic [VALUE_BITS-1:0]   rd_data_reg;
    logic                    mem_we;
    logic                    mem_re;
    logic [AW-1:0]           mem_waddr;
    logic [VALUE_BITS-1:0]   mem_wdata;

    logic                    accept;
    logic                    cmd_is_op;
    alu_op_t                 cmd_op;
    logic                    stack_full;
    logic                    stack_short;
    logic [CW-1:0]           cnt_m2;
    logic [AW-1:0]           second_addr;
    logic [VALUE_BITS+IO_BITS-1:0] v_ext;
    logic [VALUE_BITS-1:0]   v_trunc;
    logic [VALUE_BITS+IO_BITS-1:0] top_sext;
    logic [IO_BITS-1:0]      top_out;
    logic [DEPTH_W+CW-1:0]   depth_wide;

    rpn_alu_req_t            alu_req;
    rpn_alu_rsp_t            alu_rsp;
    logic [VALUE_BITS-1:0]   alu_res;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    // command decode
    always_comb begin
        cmd_is_op = 1'b1;
        cmd_op    = ALU_ADD;
        unique case (s_command)
            CMD_ADD: cmd_op = ALU_ADD;
            CMD_SUB: cmd_op = ALU_SUB;
            CMD_MUL: cmd_op = ALU_MUL;
            CMD_DIV: cmd_op = ALU_DIV;
            default: cmd_is_op = 1'b0;
        endcase
    end

    // stack bounds and addressing
    assign stack_full  = (count_reg >= CW'(STACK_DEPTH));
    assign stack_short = (count_reg < CW'(2));
    assign cnt_m2      = count_reg - CW'(2);
    assign second_addr = cnt_m2[AW-1:0];

    // word resizing at the ports
    assign v_ext      = {{VALUE_BITS{s_value[IO_BITS-1]}}, s_value};
    assign v_trunc    = v_ext[VALUE_BITS-1:0];
    assign top_sext   = {{IO_BITS{top_reg[VALUE_BITS-1]}}, top_reg};
    assign top_out    = (count_reg == '0) ? '0 : top_sext[IO_BITS-1:0];
    assign depth_wide = {{DEPTH_W{1'b0}}, count_reg};

    // arithmetic unit: second entry is the left operand, top the right
    assign alu_req.start = (state_reg == S_START);
    assign alu_req.op    = op_reg;

    rpn_alu #(
        .VALUE_BITS (VALUE_BITS)
    ) u_alu (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (alu_req),
        .left_op  (rd_data_reg),
        .right_op (top_reg),
        .rsp      (alu_rsp),
        .result   (alu_res)
    );

    // sequencer next state
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        top_next      = top_reg;
        status_next   = status_reg;
        op_next       = op_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_top_next    = m_top_reg;
        m_depth_next  = m_depth_reg;
        m_status_next = m_status_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata     = v_trunc;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next = ST_OK;
                    state_next  = S_FINISH;
                    priority if (s_command == CMD_PUSH) begin
                        if (!stack_full) begin
                            mem_we     = 1'b1;
                            top_next   = v_trunc;
                            count_next = count_reg + 1'b1;
                        end else begin
                            status_next = ST_FULL;
                        end
                    end else if (cmd_is_op) begin
                        if (stack_short) begin
                            // short stack: push zero in place of a result
                            mem_we      = 1'b1;
                            mem_wdata   = '0;
                            top_next    = '0;
                            count_next  = count_reg + 1'b1;
                            status_next = ST_SHORT;
                        end else begin
                            mem_re     = 1'b1;
                            op_next    = cmd_op;
                            state_next = S_START;
                        end
                    end else begin
                        // unknown command leaves the stack alone
                        state_next = S_FINISH;
                    end
                end
            end
            S_START: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (alu_rsp.done) begin
                    mem_we      = 1'b1;
                    mem_waddr   = second_addr;
                    mem_wdata   = alu_res;
                    top_next    = alu_res;
                    count_next  = count_reg - 1'b1;
                    status_next = alu_rsp.status;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_top_next    = top_out;
                    m_depth_next  = depth_wide[DEPTH_W-1:0];
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            top_reg      <= top_next;
            status_reg   <= status_next;
            op_reg       <= op_next;
            m_top_reg    <= m_top_next;
            m_depth_reg  <= m_depth_next;
            m_status_reg <= m_status_next;
        end
    end

    // stack memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[second_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_top_value   = m_top_reg;
    assign m_stack_depth = m_depth_reg;
    assign m_status      = m_status_reg;

`ifndef SYNTHESIS
    // a completed operation pops exactly one entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |=> count_reg == ($past(count_reg) - 1'b1))
        else $error("operator did not pop one entry");

    // the arithmetic unit only answers while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> state_reg == S_EXEC)
        else $error("arithmetic result outside execute state");

    // a push onto a full stack leaves the depth unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == CMD_PUSH && stack_full) |=> $stable(count_reg))
        else $error("push to full stack changed depth");

    // an operator reaches the unit only with two entries on the stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_req.start |-> count_reg >= CW'(2))
        else $error("operator started on short stack");
`endif

endmodule
